// ===== rtl/tlbpt_pkg.sv =====
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int ADDR_W          = 16;
    localparam int CNT_W           = 32;
    localparam int DEF_OFFSET_BITS = 8;
    localparam int DEF_TLB_ENTRIES = 16;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_TABLE  = 3'b100
    } state_t;

endpackage

// ===== rtl/tlbpt_cell.sv =====
`timescale 1ns / 1ps

module tlbpt_cell #(
    parameter int PAGE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic [PAGE_BITS-1:0] prev_tag,
    input  logic [PAGE_BITS-1:0] prev_frame,
    input  logic                 prev_valid,
    input  logic [PAGE_BITS-1:0] lookup_page,
    output logic [PAGE_BITS-1:0] tag,
    output logic [PAGE_BITS-1:0] frame,
    output logic                 valid,
    output logic                 match,
    output logic [PAGE_BITS-1:0] match_frame
);

    logic [PAGE_BITS-1:0] tag_reg;
    logic [PAGE_BITS-1:0] frame_reg;
    logic                 valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            tag_reg   <= prev_tag;
            frame_reg <= prev_frame;
        end
    end

    assign tag         = tag_reg;
    assign frame       = frame_reg;
    assign valid       = valid_reg;
    assign match       = valid_reg && (tag_reg == lookup_page);
    assign match_frame = match ? frame_reg : '0;

endmodule

// ===== rtl/tlbpt_page_table.sv =====
`timescale 1ns / 1ps

module tlbpt_page_table #(
    parameter int PAGE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [PAGE_BITS-1:0] wr_addr,
    input  logic [PAGE_BITS:0]   wr_data,
    input  logic [PAGE_BITS-1:0] rd_addr,
    output logic [PAGE_BITS:0]   rd_data,
    output logic                 ready
);

    localparam int DEPTH = 1 << PAGE_BITS;

    logic [PAGE_BITS:0]   mem [DEPTH];
    logic [PAGE_BITS:0]   rd_data_reg;
    logic [PAGE_BITS-1:0] clr_addr_reg;
    logic                 clearing_reg;
    logic                 mem_we;
    logic [PAGE_BITS-1:0] mem_wa;
    logic [PAGE_BITS:0]   mem_wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (clearing_reg) begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end else begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

// ===== rtl/tlb_page_table_address_translator_core.sv =====
`timescale 1ns / 1ps

// Address translator with a FIFO-replaced TLB and a demand-filled page table.
// Input channel s_*: one 16-bit logical address per item. Result channel m_*:
// physical address, TLB hit and page fault flags, and running hit and fault
// totals that include the current item. One result per input item.
// Each item goes through accept, TLB search in the row of TLB cells
// (the page table read is issued in the same cycle), then resolve and update.
// The result is valid in the cycle after the update and waits in the output
// register while the next item is accepted and searched; the update of that
// next item holds until the output register is free.
// TLB replacement shifts a new entry into the head cell; the oldest entry
// drops off the tail cell. Pages get frames in allocation order.
// After reset the page table runs a clearing pass over all 2^(16-OFFSET_BITS)
// entries (256 by default) with s_ready low. Counters, TLB valid bits and the
// frame pointer clear at once.
// A new item is accepted only after the update of the item before it.

module tlb_page_table_address_translator_core #(
    parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS,
    parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0] s_logical_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tlbpt_pkg::ADDR_W-1:0] m_physical_address,
    output logic                         m_tlb_hit,
    output logic                         m_page_fault,
    output logic [tlbpt_pkg::CNT_W-1:0]  m_hit_total,
    output logic [tlbpt_pkg::CNT_W-1:0]  m_fault_total
);

    import tlbpt_pkg::*;

    localparam int PAGE_BITS = ADDR_W - OFFSET_BITS;
    localparam logic [PAGE_BITS:0] FRAME_LIMIT = (PAGE_BITS + 1)'(1 << PAGE_BITS);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]      addr_reg;
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offset;

    logic                   hit_reg;
    logic [PAGE_BITS-1:0]   hit_frame_reg;
    logic [PAGE_BITS:0]     next_free_reg;
    logic [CNT_W-1:0]       hit_cnt_reg;
    logic [CNT_W-1:0]       fault_cnt_reg;
    logic [CNT_W-1:0]       hit_cnt_next;
    logic [CNT_W-1:0]       fault_cnt_next;

    logic                   m_valid_reg;
    logic [ADDR_W-1:0]      m_phys_reg;
    logic                   m_hit_reg;
    logic                   m_fault_reg;
    logic [CNT_W-1:0]       m_hit_total_reg;
    logic [CNT_W-1:0]       m_fault_total_reg;

    logic                   pt_ready;
    logic [PAGE_BITS:0]     pt_rd_data;
    logic                   pt_mapped;
    logic                   slot_free;
    logic                   update;
    logic                   fault;
    logic [PAGE_BITS-1:0]   frame;

    logic [PAGE_BITS-1:0]   cell_tag   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   cell_frame [TLB_ENTRIES];
    logic                   cell_valid [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] cell_match;
    logic [PAGE_BITS-1:0]   cell_mframe [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   search_frame;
    logic                   tlb_shift;

    assign page   = addr_reg[ADDR_W-1:OFFSET_BITS];
    assign offset = addr_reg[OFFSET_BITS-1:0];

    assign tlb_shift = update && !hit_reg;

    for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_head
            tlbpt_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (tlb_shift),
                .prev_tag    (page),
                .prev_frame  (frame),
                .prev_valid  (1'b1),
                .lookup_page (page),
                .tag         (cell_tag[i]),
                .frame       (cell_frame[i]),
                .valid       (cell_valid[i]),
                .match       (cell_match[i]),
                .match_frame (cell_mframe[i])
            );
        end else begin : g_body
            tlbpt_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (tlb_shift),
                .prev_tag    (cell_tag[i-1]),
                .prev_frame  (cell_frame[i-1]),
                .prev_valid  (cell_valid[i-1]),
                .lookup_page (page),
                .tag         (cell_tag[i]),
                .frame       (cell_frame[i]),
                .valid       (cell_valid[i]),
                .match       (cell_match[i]),
                .match_frame (cell_mframe[i])
            );
        end
    end

    always_comb begin
        search_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            search_frame = search_frame | cell_mframe[i];
        end
    end

    tlbpt_page_table #(.PAGE_BITS(PAGE_BITS)) u_page_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (update && fault),
        .wr_addr (page),
        .wr_data ({1'b1, frame}),
        .rd_addr (page),
        .rd_data (pt_rd_data),
        .ready   (pt_ready)
    );

    assign pt_mapped = pt_rd_data[PAGE_BITS];
    assign slot_free = !m_valid_reg || m_ready;
    assign update    = (state_reg == ST_TABLE) && slot_free;
    assign fault     = !hit_reg && !pt_mapped;

    always_comb begin
        if (hit_reg) begin
            frame = hit_frame_reg;
        end else if (pt_mapped) begin
            frame = pt_rd_data[PAGE_BITS-1:0];
        end else begin
            frame = next_free_reg[PAGE_BITS-1:0];
        end
    end

    assign hit_cnt_next   = hit_cnt_reg + CNT_W'(hit_reg);
    assign fault_cnt_next = fault_cnt_reg + CNT_W'(fault);

    assign s_ready = (state_reg == ST_IDLE) && pt_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = ST_TABLE;
            end
            ST_TABLE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_free_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (update) begin
                hit_cnt_reg   <= hit_cnt_next;
                fault_cnt_reg <= fault_cnt_next;
                if (fault && (next_free_reg < FRAME_LIMIT)) begin
                    next_free_reg <= next_free_reg + 1'b1;
                end
            end
            if (update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            addr_reg <= s_logical_address;
        end
        if (state_reg == ST_SEARCH) begin
            hit_reg       <= |cell_match;
            hit_frame_reg <= search_frame;
        end
        if (update) begin
            m_phys_reg        <= {frame, offset};
            m_hit_reg         <= hit_reg;
            m_fault_reg       <= fault;
            m_hit_total_reg   <= hit_cnt_next;
            m_fault_total_reg <= fault_cnt_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = m_phys_reg;
    assign m_tlb_hit          = m_hit_reg;
    assign m_page_fault       = m_fault_reg;
    assign m_hit_total        = m_hit_total_reg;
    assign m_fault_total      = m_fault_total_reg;

`ifndef SYNTHESIS
    a_hit_excludes_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tlb_hit && m_page_fault))
        else $error("hit and fault flagged together");

    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in work");

    a_frame_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && fault) |=> (next_free_reg == $past(next_free_reg) + 1'b1))
        else $error("frame pointer did not advance on fault");

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !pt_ready |-> !s_ready)
        else $error("item accepted during page table clear");
`endif

endmodule

// ===== dv/tlb_page_table_address_translator_core_tb.sv =====
`timescale 1ns / 1ps

module tlb_page_table_address_translator_core_tb;

    import tlbpt_pkg::*;

    localparam int OFFSET_BITS = DEF_OFFSET_BITS;
    localparam int TLB_DEPTH   = DEF_TLB_ENTRIES;
    localparam int PAGE_BITS   = ADDR_W - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;

    typedef logic [PAGE_BITS-1:0]   page_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  faults;
    } xlat_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SLOW
    } rx_mode_t;

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic [ADDR_W-1:0] s_logical_address = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic [ADDR_W-1:0] m_physical_address;
    logic              m_tlb_hit;
    logic              m_page_fault;
    logic [CNT_W-1:0]  m_hit_total;
    logic [CNT_W-1:0]  m_fault_total;

    page_t            tlb_page  [TLB_DEPTH];
    page_t            tlb_frame [TLB_DEPTH];
    logic             tlb_live  [TLB_DEPTH];
    int               fifo_ptr;
    page_t            frame_of_page [PAGE_COUNT];
    logic             page_has_frame [PAGE_COUNT];
    logic [PAGE_BITS:0] free_frame;
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] fault_cnt;

    xlat_t    pending_xlat [$];
    int       mismatch_count = 0;
    int       burst_left;
    rx_mode_t rx_mode        = RX_STREAM;
    int       rx_phase_left  = 0;

    tlb_page_table_address_translator_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .TLB_ENTRIES (TLB_DEPTH)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_logical_address  (s_logical_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_tlb_hit          (m_tlb_hit),
        .m_page_fault       (m_page_fault),
        .m_hit_total        (m_hit_total),
        .m_fault_total      (m_fault_total)
    );

    always #2 aclk = ~aclk;

    function automatic xlat_t translate(input logic [ADDR_W-1:0] addr);
        page_t   page;
        offset_t offset;
        page_t   frame;
        xlat_t   r;
        page     = addr[ADDR_W-1:OFFSET_BITS];
        offset   = addr[OFFSET_BITS-1:0];
        frame    = '0;
        r        = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
            if (tlb_live[i] && tlb_page[i] == page) begin
                frame = tlb_frame[i];
                r.hit = 1'b1;
            end
        end
        if (r.hit) begin
            hit_cnt = hit_cnt + 1'b1;
        end else begin
            if (page_has_frame[page]) begin
                frame = frame_of_page[page];
            end else begin
                frame                = free_frame[PAGE_BITS-1:0];
                frame_of_page[page]  = frame;
                page_has_frame[page] = 1'b1;
                if (free_frame < PAGE_COUNT) free_frame = free_frame + 1'b1;
                fault_cnt = fault_cnt + 1'b1;
                r.fault   = 1'b1;
            end
            tlb_page[fifo_ptr]  = page;
            tlb_frame[fifo_ptr] = frame;
            tlb_live[fifo_ptr]  = 1'b1;
            fifo_ptr = (fifo_ptr + 1 >= TLB_DEPTH) ? 0 : fifo_ptr + 1;
        end
        r.phys_addr = {frame, offset};
        r.hits      = hit_cnt;
        r.faults    = fault_cnt;
        return r;
    endfunction

    task automatic send_item(input logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid           <= 1'b1;
        s_logical_address <= addr;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        pending_xlat.push_back(translate(addr));
    endtask

    task automatic test_field_extremes();
        send_item(16'h0000);
        send_item(16'hFFFF);
        send_item(16'h00FF);
        send_item(16'hFF00);
        send_item(16'h5A5A);
        send_item(16'hA5A5);
    endtask

    // fill the TLB with new pages so page 0 drops out, then revisit it
    task automatic test_tlb_eviction();
        for (int p = 1; p <= TLB_DEPTH; p++) begin
            send_item({page_t'(p), offset_t'($urandom)});
        end
        send_item({page_t'(0), offset_t'($urandom)});
        send_item({page_t'(0), offset_t'($urandom)});
    endtask

    task automatic test_working_sets(input int n_items);
        page_t             ws [$];
        int                sent;
        int                ws_size;
        int                run;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < n_items) begin
            ws_size = $urandom_range(1, 24);
            ws.delete();
            for (int k = 0; k < ws_size; k++) begin
                ws.push_back(page_t'($urandom_range(0, PAGE_COUNT - 1)));
            end
            run = $urandom_range(8, 64);
            for (int k = 0; k < run && sent < n_items; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    addr = ADDR_W'($urandom);
                end else begin
                    addr = {ws[$urandom_range(0, ws_size - 1)], offset_t'($urandom)};
                end
                send_item(addr);
                sent++;
            end
        end
    endtask

    // touch every page once in shuffled order so the frame pool runs out
    task automatic test_page_sweep();
        int order [PAGE_COUNT];
        int j;
        int t;
        for (int i = 0; i < PAGE_COUNT; i++) order[i] = i;
        for (int i = PAGE_COUNT - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < PAGE_COUNT; i++) begin
            send_item({page_t'(order[i]), offset_t'($urandom)});
        end
    endtask

    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= rx_mode_t'($urandom_range(0, 2));
            rx_phase_left <= $urandom_range(16, 96);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        xlat_t want;
        xlat_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_physical_address, m_tlb_hit, m_page_fault, m_hit_total, m_fault_total};
            if (pending_xlat.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected item: phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                             got.phys_addr, got.hit, got.fault, got.hits, got.faults);
                end
            end else begin
                want = pending_xlat.pop_front();
                if (got.phys_addr !== want.phys_addr || got.hit !== want.hit ||
                    got.fault !== want.fault || got.hits !== want.hits ||
                    got.faults !== want.faults) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                                 want.phys_addr, want.hit, want.fault, want.hits, want.faults);
                        $display("          got phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                                 got.phys_addr, got.hit, got.fault, got.hits, got.faults);
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < TLB_DEPTH; i++) tlb_live[i] = 1'b0;
        for (int i = 0; i < PAGE_COUNT; i++) page_has_frame[i] = 1'b0;
        fifo_ptr       = 0;
        free_frame     = '0;
        hit_cnt        = '0;
        fault_cnt      = '0;
        burst_left     = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_tlb_eviction();
        test_working_sets(1300);
        test_page_sweep();
        test_working_sets(270);

        s_valid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (mismatch_count == 0 && pending_xlat.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
